/* rtl/scope_trigger_capture_core_macros.svh */
// Assertion helpers for the checker in rtl/stc_checker.sv.
`ifndef SCOPE_TRIGGER_CAPTURE_CORE_MACROS_SVH
`define SCOPE_TRIGGER_CAPTURE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define STC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset.
`define STC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/stc_pkg.sv */
package stc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 9;
  localparam int LEN_W      = 10;
  localparam int TIMER_W    = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;

  localparam logic [LEN_W-1:0]   CAPTURE_LENGTH_RST = LEN_W'(400);
  localparam logic [TIMER_W-1:0] ARM_TIMEOUT_RST    = TIMER_W'(16000);
  localparam logic [TIMER_W-1:0] HOLDOFF_LENGTH_RST = TIMER_W'(4800);

  // frames granted by an input update
  localparam logic [1:0] FRAMES_RELOAD = 2'd2;

  // tuser bit positions on the input channel
  localparam int USER_STREAMING = 0;
  localparam int USER_UPDATED   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPTURE_LENGTH = 2'd0,
    CFG_ARM_TIMEOUT    = 2'd1,
    CFG_HOLDOFF_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_WAIT_LOW  = 3'd0,
    MODE_WAIT_HIGH = 3'd1,
    MODE_CAPTURE   = 3'd2,
    MODE_HOLDOFF   = 3'd3,
    MODE_SLEEP     = 3'd4
  } mode_t;

  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]           position;
    logic                       last;
  } result_t;

endpackage

/* rtl/scope_trigger_capture_core.sv */
// Scope trigger and frame capture. One sample transaction is taken per clock
// whenever the result register is empty or being drained; the sample is judged
// and any captured sample is registered in the result register, so the sustained
// rate is one item per cycle and only out_tready back-pressure slows it. Arming
// waits for a sample at or below zero, then one above zero; if none
// arrives within arm_timeout+1 waiting samples, capture is forced. A frame is
// capture_length samples (0 acts as 1, clamped to MAX_CAPTURE) and the final
// one carries tlast. Frames are emitted only while the frame budget is nonzero;
// with the input not streaming the budget drops per frame and the block sleeps
// at zero until a transaction with the update flag reloads it to two. After a
// frame the block idles holdoff_length+1 samples before rearming. Write the
// configuration only while no transaction is in flight.
module scope_trigger_capture_core #(
  parameter int MAX_CAPTURE = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [stc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // sample input
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [stc_pkg::SAMPLE_W-1:0]        in_tdata,   // [15:0] sample
  input  logic [stc_pkg::IN_USER_W-1:0]       in_tuser,   // [0] input_streaming, [1] input_updated
  // captured samples
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [stc_pkg::OUT_DATA_W-1:0]      out_tdata,  // [15:0] captured_sample, [24:16] position
  output logic                                out_tlast   // last_of_frame
);
  import stc_pkg::*;

  logic [LEN_W-1:0]   capture_length_r;
  logic [TIMER_W-1:0] arm_timeout_r;
  logic [TIMER_W-1:0] holdoff_length_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic [POS_W-1:0]           out_pos_r;
  logic                       out_last_r;

  logic    in_accept;
  result_t result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_length_r <= CAPTURE_LENGTH_RST;
      arm_timeout_r    <= ARM_TIMEOUT_RST;
      holdoff_length_r <= HOLDOFF_LENGTH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAPTURE_LENGTH: capture_length_r <= cfg_data[LEN_W-1:0];
        CFG_ARM_TIMEOUT:    arm_timeout_r    <= cfg_data[TIMER_W-1:0];
        CFG_HOLDOFF_LENGTH: holdoff_length_r <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  stc_trigger_fsm #(
    .MAX_CAPTURE(MAX_CAPTURE)
  ) u_fsm (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_accept),
    .sample         (in_tdata),
    .streaming      (in_tuser[USER_STREAMING]),
    .updated        (in_tuser[USER_UPDATED]),
    .capture_length (capture_length_r),
    .arm_timeout    (arm_timeout_r),
    .holdoff_length (holdoff_length_r),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= result.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_sample_r <= result.sample;
      out_pos_r    <= result.position;
      out_last_r   <= result.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - SAMPLE_W - POS_W)'(0), out_pos_r, out_sample_r};
  assign out_tlast  = out_last_r;

endmodule

/* rtl/stc_trigger_fsm.sv */
module stc_trigger_fsm #(
  parameter int MAX_CAPTURE = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic signed [stc_pkg::SAMPLE_W-1:0] sample,
  input  logic                                streaming,
  input  logic                                updated,
  input  logic [stc_pkg::LEN_W-1:0]           capture_length,
  input  logic [stc_pkg::TIMER_W-1:0]         arm_timeout,
  input  logic [stc_pkg::TIMER_W-1:0]         holdoff_length,
  output stc_pkg::result_t                    result
);
  import stc_pkg::*;

  localparam int IDX_W = $clog2(MAX_CAPTURE);
  localparam int CW    = $clog2(MAX_CAPTURE + 1);
  localparam int EW    = (CW > LEN_W) ? CW : LEN_W;

  mode_t              mode_r, mode_nxt;
  logic [IDX_W-1:0]   index_r, index_nxt;
  logic [TIMER_W-1:0] count_r, count_nxt;
  logic [1:0]         frames_r, frames_nxt;

  logic [EW-1:0] len_ext, len_eff, idx_inc;
  logic          is_low, hit, expired, last;
  mode_t         mode_cur;
  logic [1:0]    frames_cur;
  logic [IDX_W-1:0] index_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CAPTURE;
      index_r  <= '0;
      count_r  <= '0;
      frames_r <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      index_r  <= index_nxt;
      count_r  <= count_nxt;
      frames_r <= frames_nxt;
    end
  end

  always_comb begin
    len_ext = EW'(capture_length);
    if (len_ext == '0) begin
      len_eff = EW'(1);
    end else if (len_ext > EW'(MAX_CAPTURE)) begin
      len_eff = EW'(MAX_CAPTURE);
    end else begin
      len_eff = len_ext;
    end
  end

  always_comb begin
    is_low = sample[SAMPLE_W-1] || (sample == '0);

    // an update is applied before the sample is consumed
    mode_cur   = mode_r;
    index_cur  = index_r;
    frames_cur = updated ? FRAMES_RELOAD : frames_r;
    if (updated && mode_r == MODE_SLEEP) begin
      mode_cur  = MODE_CAPTURE;
      index_cur = '0;
    end

    mode_nxt   = mode_cur;
    index_nxt  = index_cur;
    frames_nxt = frames_cur;
    count_nxt  = count_r;
    expired    = (count_r == '0);
    hit        = 1'b0;
    idx_inc    = EW'(index_cur) + EW'(1);
    last       = (idx_inc >= len_eff);

    result.valid    = 1'b0;
    result.sample   = sample;
    result.position = POS_W'(index_cur);
    result.last     = last;

    case (mode_cur)
      MODE_WAIT_LOW, MODE_WAIT_HIGH: begin
        if (!expired) count_nxt = count_r - TIMER_W'(1);
        hit = (mode_cur == MODE_WAIT_LOW) ? is_low : !is_low;
        if (hit && mode_cur == MODE_WAIT_LOW) begin
          mode_nxt = MODE_WAIT_HIGH;
        end else if (hit || expired) begin
          mode_nxt  = MODE_CAPTURE;
          index_nxt = '0;
        end
      end
      MODE_CAPTURE: begin
        result.valid = (frames_cur != '0);
        index_nxt    = IDX_W'(idx_inc);
        if (last) begin
          if (!streaming && frames_cur != '0) frames_nxt = frames_cur - 2'd1;
          if (!streaming && frames_nxt == '0) begin
            mode_nxt = MODE_SLEEP;
          end else begin
            mode_nxt  = MODE_HOLDOFF;
            count_nxt = holdoff_length;
          end
          index_nxt = '0;
        end
      end
      MODE_HOLDOFF: begin
        if (expired) begin
          mode_nxt  = MODE_WAIT_LOW;
          count_nxt = arm_timeout;
        end else begin
          count_nxt = count_r - TIMER_W'(1);
        end
      end
      MODE_SLEEP: begin
        mode_nxt = MODE_SLEEP;
      end
      default: begin
        mode_nxt = MODE_SLEEP;
      end
    endcase
  end

endmodule

/* rtl/stc_checker.sv */
`include "scope_trigger_capture_core_macros.svh"

module stc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [stc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic                               out_tlast
);
  import stc_pkg::*;

  localparam int PAD_LO = SAMPLE_W + POS_W;

  // a result held under back-pressure must not change
  `STC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output changed while stalled")

  // an empty result register never blocks the input
  `STC_ASSERT_NOW(a_in_free, !out_tvalid, in_tready, "input stalled with empty output")

  // every new result comes from an input transaction in the cycle before
  `STC_ASSERT_NOW(a_out_cause, $rose(out_tvalid), $past(in_tvalid && in_tready), "result without input")

  // padding bits above the position field stay zero
  `STC_ASSERT_NOW(a_out_pad, out_tvalid, out_tdata[OUT_DATA_W-1:PAD_LO] == '0, "tdata padding not zero")

endmodule

bind scope_trigger_capture_core stc_checker u_stc_checker (.*);

/* tb/capture_checker.sv */
`timescale 1ns / 100ps

module capture_checker #(
  parameter int MAX_CAPTURE = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [stc_pkg::SAMPLE_W-1:0]   in_tdata,
  input  logic [stc_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [stc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tlast,
  output int                             mismatches,
  output int                             pending
);
  import stc_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] smp;
    logic [POS_W-1:0]    pos;
    logic                last;
  } capture_t;

  capture_t frame_samples[$];

  // shadow registers
  logic [LEN_W-1:0]   len_reg;
  logic [TIMER_W-1:0] arm_reg;
  logic [TIMER_W-1:0] hold_reg;

  // shadow state
  mode_t              mode_q;
  logic [12:0]        cap_idx;
  logic [TIMER_W:0]   count_q;
  logic [1:0]         budget;

  task automatic judge_sample(input logic [SAMPLE_W-1:0] smp, input logic strm,
                              input logic upd);
    logic       low_s;
    logic       hit;
    logic       expired;
    logic       is_last;
    logic [13:0] span;
    capture_t   r;
    low_s = smp[SAMPLE_W-1] || (smp == '0);
    if (upd) begin
      budget = FRAMES_RELOAD;
      if (mode_q == MODE_SLEEP) begin
        mode_q  = MODE_CAPTURE;
        cap_idx = '0;
      end
    end
    case (mode_q)
      MODE_WAIT_LOW, MODE_WAIT_HIGH: begin
        expired = (count_q == '0);
        if (!expired) count_q = count_q - 1'b1;
        hit = (mode_q == MODE_WAIT_LOW) ? low_s : !low_s;
        // a hit beats the timeout
        if (hit && mode_q == MODE_WAIT_LOW) begin
          mode_q = MODE_WAIT_HIGH;
        end else if (hit || expired) begin
          mode_q  = MODE_CAPTURE;
          cap_idx = '0;
        end
      end
      MODE_CAPTURE: begin
        if (len_reg == '0) span = 14'd1;
        else if (len_reg > MAX_CAPTURE) span = 14'(MAX_CAPTURE);
        else span = 14'(len_reg);
        is_last = (14'(cap_idx) + 14'd1) >= span;
        if (budget != '0) begin
          r.smp  = smp;
          r.pos  = cap_idx[POS_W-1:0];
          r.last = is_last;
          frame_samples.push_back(r);
        end
        cap_idx = cap_idx + 1'b1;
        if (is_last) begin
          if (!strm && budget != '0) budget = budget - 1'b1;
          if (budget == '0 && !strm) begin
            mode_q = MODE_SLEEP;
          end else begin
            mode_q  = MODE_HOLDOFF;
            count_q = (TIMER_W+1)'(hold_reg);
          end
          cap_idx = '0;
        end
      end
      MODE_HOLDOFF: begin
        if (count_q == '0) begin
          mode_q  = MODE_WAIT_LOW;
          count_q = (TIMER_W+1)'(arm_reg);
        end else begin
          count_q = count_q - 1'b1;
        end
      end
      default: ;  // asleep: sample dropped
    endcase
  endtask

  always @(posedge clk) begin
    capture_t got;
    capture_t want;
    if (!rst_n) begin
      len_reg  = CAPTURE_LENGTH_RST;
      arm_reg  = ARM_TIMEOUT_RST;
      hold_reg = HOLDOFF_LENGTH_RST;
      mode_q   = MODE_CAPTURE;
      cap_idx  = '0;
      count_q  = '0;
      budget   = '0;
      frame_samples.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CAPTURE_LENGTH: len_reg  = cfg_data[LEN_W-1:0];
          CFG_ARM_TIMEOUT:    arm_reg  = cfg_data[TIMER_W-1:0];
          CFG_HOLDOFF_LENGTH: hold_reg = cfg_data[TIMER_W-1:0];
          default: ;  // unmapped index
        endcase
      end
      if (in_tvalid && in_tready)
        judge_sample(in_tdata, in_tuser[USER_STREAMING], in_tuser[USER_UPDATED]);
      if (out_tvalid && out_tready) begin
        got.smp  = out_tdata[SAMPLE_W-1:0];
        got.pos  = out_tdata[SAMPLE_W +: POS_W];
        got.last = out_tlast;
        if (frame_samples.size() == 0) begin
          $display("%0t: transaction expected none actual sample %h position %0d last %0b",
                   $time, got.smp, got.pos, got.last);
          mismatches++;
        end else begin
          want = frame_samples.pop_front();
          if (got.smp !== want.smp) begin
            $display("%0t: sample expected %h actual %h", $time, want.smp, got.smp);
            mismatches++;
          end
          if (got.pos !== want.pos) begin
            $display("%0t: position expected %0d actual %0d", $time, want.pos, got.pos);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            mismatches++;
          end
          if (out_tdata[OUT_DATA_W-1:SAMPLE_W+POS_W] !== '0) begin
            $display("%0t: tdata padding expected 0 actual %h", $time,
                     out_tdata[OUT_DATA_W-1:SAMPLE_W+POS_W]);
            mismatches++;
          end
        end
      end
    end
    pending <= frame_samples.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import stc_pkg::*;

  localparam int MAX_CAPTURE = 512;
  // index past the last register, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  int                    mismatches;
  int                    pending;

  int send_idle_pct = 6;
  int recv_idle_pct = 53;

  always #5 clk = ~clk;

  scope_trigger_capture_core #(.MAX_CAPTURE(MAX_CAPTURE)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  capture_checker #(.MAX_CAPTURE(MAX_CAPTURE)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic strm,
                           input logic upd);
    logic [IN_USER_W-1:0] user;
    user                 = '0;
    user[USER_STREAMING] = strm;
    user[USER_UPDATED]   = upd;
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    in_tuser  <= user;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // stop sending and wait for every expected capture to come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] len, input logic [CFG_DATA_W-1:0] arm,
                          input logic [CFG_DATA_W-1:0] hold);
    wait_drained();
    write_reg(CFG_CAPTURE_LENGTH, len);
    write_reg(CFG_ARM_TIMEOUT, arm);
    write_reg(CFG_HOLDOFF_LENGTH, hold);
  endtask

  // bursts of zero-crossing waveforms mixed with stuck-high, stuck-low and noise
  task automatic run_signal(input int count);
    int          style;
    int          left;
    int          run;
    logic        neg;
    logic [15:0] smp;
    style = 0;
    left  = 0;
    run   = 0;
    neg   = 1'b0;
    for (int k = 0; k < count; k++) begin
      if (left == 0) begin
        style = $urandom_range(9);
        left  = $urandom_range(40, 4);
      end
      left--;
      if (run == 0) begin
        neg = ~neg;
        run = $urandom_range(8, 1);
      end
      run--;
      case (style)
        0:       smp = 16'($urandom_range(32767, 1));
        1:       smp = 16'(0 - int'($urandom_range(32768, 0)));
        2:       smp = 16'($urandom);
        default: smp = neg ? 16'(0 - int'($urandom_range(32768, 0)))
                           : 16'($urandom_range(32767, 1));
      endcase
      send_item(smp, $urandom_range(99) < 85, $urandom_range(99) < 4);
      if ($urandom_range(199) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: length 4, timeout 3, holdoff 2
    set_regs(20'd4, 20'd3, 20'd2);
    send_item(16'h7FFF, 1'b1, 1'b1);  // budget reload while capturing
    send_item(16'h8000, 1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'hFFFF, 1'b1, 1'b0);  // frame end, holdoff
    repeat (3) send_item(16'h0001, 1'b1, 1'b0);
    repeat (4) send_item(16'h0001, 1'b1, 1'b0);  // never low: arm timeout forces capture
    send_item(16'h1111, 1'b0, 1'b0);
    send_item(16'h2222, 1'b0, 1'b0);
    send_item(16'h3333, 1'b0, 1'b0);
    send_item(16'h4444, 1'b0, 1'b0);  // input stopped: budget drops to one
    repeat (3) send_item(16'h0002, 1'b0, 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);  // low
    send_item(16'h8000, 1'b1, 1'b0);
    send_item(16'h0001, 1'b1, 1'b0);  // rising crossing, not captured
    send_item(16'h5555, 1'b1, 1'b0);
    send_item(16'hAAAA, 1'b1, 1'b0);
    // shrink the frame below the current index: next sample ends it
    wait_drained();
    write_reg(CFG_CAPTURE_LENGTH, 20'd2);
    send_item(16'h7FFF, 1'b0, 1'b0);  // budget to zero, sleep
    send_item(16'h0123, 1'b0, 1'b0);  // ignored while asleep
    send_item(16'h0001, 1'b1, 1'b1);  // wake

    set_regs(20'd0, 20'd0, 20'd0);
    run_signal(150);
    set_regs(20'd7, 20'd5, 20'd3);
    run_signal(200);

    send_idle_pct = 53;
    recv_idle_pct = 6;
    set_regs(20'd512, 20'hFFFFF, 20'd1);
    run_signal(550);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_regs(20'hFFC03, 20'd1, 20'd5);
    write_reg(CFG_SPARE, 20'h00000);
    run_signal(200);
    set_regs(20'hFFFFF, 20'd2, 20'd2);
    run_signal(80);
    // longest holdoff last, so the long wait runs out the stimulus
    set_regs(20'd2, 20'd0, 20'hFFFFF);
    run_signal(60);

    in_tvalid <= 1'b0;
    for (int w = 0; w < 5000 && pending != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
